// File: rtl/scfr_pkg.sv
//------------------------------------------------------------------------------
// scfr_pkg
// Shared constants, types and the CRC-16/X.25 byte update for the deframer.
//------------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

   localparam int unsigned FrameBytesDefault = 20;

   localparam logic [7:0]  SyncFirst  = 8'h47;
   localparam logic [7:0]  SyncSecond = 8'h44;
   localparam logic [15:0] CrcInit    = 16'hFFFF;
   localparam logic [15:0] CrcXorOut  = 16'hFFFF;
   localparam logic [15:0] CrcPoly    = 16'h8408;

   // reflected CRC, one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   localparam logic [15:0] CrcHeader = crc_byte(crc_byte(CrcInit, SyncFirst), SyncSecond);

   typedef struct packed {
      logic load_header;
      logic feed;
      logic clear;
   } crc_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/scfr_req_if.sv
//------------------------------------------------------------------------------
// scfr_req_if
// Receive-byte channel: valid/ready handshake with one serial byte per word.
//------------------------------------------------------------------------------
`default_nettype none

interface scfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/scfr_rsp_if.sv
//------------------------------------------------------------------------------
// scfr_rsp_if
// Frame-byte channel: valid/ready handshake, one frame byte with its position
// and the end-of-frame check verdict per word.
//------------------------------------------------------------------------------
`default_nettype none

interface scfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [5:0] byte_position;
   logic       frame_end;
   logic       check_passed;

   modport source (output valid, output frame_byte, output byte_position,
                   output frame_end, output check_passed, input ready);
   modport sink   (input valid, input frame_byte, input byte_position,
                   input frame_end, input check_passed, output ready);
endinterface

`default_nettype wire

// File: rtl/scfr_crc16_unit.sv
//------------------------------------------------------------------------------
// scfr_crc16_unit
// Running CRC-16/X.25 register with header preload and byte-wide update.
//------------------------------------------------------------------------------
`default_nettype none

module scfr_crc16_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire scfr_pkg::crc_ctrl_type ctrl,
   input  wire logic [7:0]            data,
   output logic [15:0]                crc
);
   import scfr_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.clear) begin
         crc_in = CrcInit;
      end else if (ctrl.load_header) begin
         crc_in = CrcHeader;
      end else if (ctrl.feed) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CrcInit;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

// File: rtl/sync_crc16_frame_receiver_core.sv
//------------------------------------------------------------------------------
// sync_crc16_frame_receiver_core
// Hunts for the 0x47 0x44 header, passes out every following frame byte with
// its position and checks the CRC-16/X.25 carried in the last two bytes.
//
//   channel  dir  word
//   req      in   rx_byte
//   rsp      out  frame_byte, byte_position, frame_end, check_passed
//
// One byte per cycle while req.ready is high; the result is registered and appears in the cycle after acceptance.
// Header bytes and hunted bytes produce no rsp word.
// req.ready drops only while a rsp word is held and rsp.ready is low.
// Synchronous reset returns to header hunt with the CRC at its initial value.
//------------------------------------------------------------------------------
`default_nettype none

module sync_crc16_frame_receiver_core #(
   parameter int unsigned FRAME_BYTES = scfr_pkg::FrameBytesDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   scfr_req_if.sink     req,
   scfr_rsp_if.source   rsp
);
   import scfr_pkg::*;

   localparam logic [5:0] LastPos     = 6'(FRAME_BYTES - 1);
   localparam logic [5:0] CheckLowPos = 6'(FRAME_BYTES - 2);

   logic       in_frame_ff, in_frame_in;
   logic       prev_sync_ff, prev_sync_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] check_low_ff, check_low_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [5:0] rsp_pos_ff, rsp_pos_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_pass_ff, rsp_pass_in;

   logic         accept;
   logic [15:0]  crc;
   crc_ctrl_type crc_ctrl;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   scfr_crc16_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (req.rx_byte),
      .crc   (crc)
   );

   always_comb begin
      in_frame_in  = in_frame_ff;
      prev_sync_in = prev_sync_ff;
      count_in     = count_ff;
      check_low_in = check_low_ff;
      crc_ctrl     = '0;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_pass_in  = rsp_pass_ff;

      if (accept) begin
         if (!in_frame_ff) begin
            if (prev_sync_ff && req.rx_byte == SyncSecond) begin
               in_frame_in          = 1'b1;
               prev_sync_in         = 1'b0;
               count_in             = 6'd2;
               crc_ctrl.load_header = 1'b1;
            end else begin
               prev_sync_in = (req.rx_byte == SyncFirst);
            end
         end else begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = req.rx_byte;
            rsp_pos_in   = count_ff;
            rsp_end_in   = 1'b0;
            rsp_pass_in  = 1'b0;
            if (count_ff < CheckLowPos) begin
               crc_ctrl.feed = 1'b1;
               count_in      = count_ff + 6'd1;
            end else if (count_ff == CheckLowPos) begin
               check_low_in = req.rx_byte;
               count_in     = count_ff + 6'd1;
            end else begin
               rsp_end_in     = 1'b1;
               rsp_pass_in    = ({req.rx_byte, check_low_ff} == (crc ^ CrcXorOut));
               in_frame_in    = 1'b0;
               prev_sync_in   = 1'b0;
               count_in       = '0;
               check_low_in   = '0;
               crc_ctrl.clear = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         prev_sync_ff <= 1'b0;
         count_ff     <= '0;
         check_low_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         prev_sync_ff <= prev_sync_in;
         count_ff     <= count_in;
         check_low_ff <= check_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_pass_ff <= rsp_pass_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.frame_byte    = rsp_byte_ff;
   assign rsp.byte_position = rsp_pos_ff;
   assign rsp.frame_end     = rsp_end_ff;
   assign rsp.check_passed  = rsp_pass_ff;

   a_end_at_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_pos_ff == LastPos)
      else $error("frame end off the last position");

   a_pass_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_end_ff |-> !rsp_pass_ff)
      else $error("check verdict before frame end");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> count_ff >= 6'd2 && count_ff <= LastPos)
      else $error("byte count out of frame");

   a_hunt_after_frame: assert property (@(posedge clock) disable iff (reset)
      accept && in_frame_ff && count_ff == LastPos |=> !in_frame_ff && crc == CrcInit)
      else $error("no return to hunt after frame");

   a_no_rsp_in_hunt: assert property (@(posedge clock) disable iff (reset)
      accept && !in_frame_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("word emitted while hunting");

endmodule

`default_nettype wire

// File: verif/tb_sync_crc16_frame_receiver_core.sv
//------------------------------------------------------------------------------
// tb_sync_crc16_frame_receiver_core
// Self-checking bench for the CRC-16/X.25 frame receiver. A table of directed
// bytes is followed by random frames, broken headers and noise. Every accepted
// byte goes through a local deframer model whose output words are compared
// with the rsp channel in order, under random idling and back-pressure.
//------------------------------------------------------------------------------
module tb_sync_crc16_frame_receiver_core;
   import scfr_pkg::*;

   localparam int unsigned FRAME_BYTES = FrameBytesDefault;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned WORD_TARGET = 1600;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [5:0] byte_position;
      logic       frame_end;
      logic       check_passed;
   } frame_word_type;

   typedef enum logic [1:0] {ROW_DATA, ROW_CHECK_LO, ROW_CHECK_HI} row_kind_type;

   typedef struct packed {
      logic [7:0]     rx_byte;
      row_kind_type   kind;
      logic           typed;
      frame_word_type word;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   scfr_req_if req_bus ();
   scfr_rsp_if rsp_bus ();

   sync_crc16_frame_receiver_core #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // deframer model state
   logic        framing        = 1'b0;
   logic        saw_sync_first = 1'b0;
   logic [5:0]  frame_offset   = '0;
   logic [15:0] crc_acc        = CrcInit;
   logic [7:0]  check_low_byte = '0;
   logic [15:0] planned_check  = '0;

   frame_word_type expected_words[$];

   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 68;
   int unsigned stall_left    = 0;
   int unsigned cycle_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_predicted = 0;
   int unsigned words_checked  = 0;
   int unsigned bytes_sent     = 0;
   int unsigned frames_good    = 0;
   int unsigned frames_bad     = 0;

   directed_row_type directed_rows [0:24] = '{
      '{8'h44, ROW_DATA,     1'b0, '0},
      '{8'h47, ROW_DATA,     1'b0, '0},
      '{8'h47, ROW_DATA,     1'b0, '0},
      '{8'h44, ROW_DATA,     1'b0, '0},
      '{8'h00, ROW_DATA,     1'b1, '{8'h00, 6'd2, 1'b0, 1'b0}},
      '{8'hFF, ROW_DATA,     1'b1, '{8'hFF, 6'd3, 1'b0, 1'b0}},
      '{8'h47, ROW_DATA,     1'b1, '{8'h47, 6'd4, 1'b0, 1'b0}},
      '{8'h44, ROW_DATA,     1'b1, '{8'h44, 6'd5, 1'b0, 1'b0}},
      '{8'h01, ROW_DATA,     1'b0, '0},
      '{8'h80, ROW_DATA,     1'b0, '0},
      '{8'h55, ROW_DATA,     1'b0, '0},
      '{8'hAA, ROW_DATA,     1'b0, '0},
      '{8'h7F, ROW_DATA,     1'b0, '0},
      '{8'hFE, ROW_DATA,     1'b0, '0},
      '{8'h10, ROW_DATA,     1'b0, '0},
      '{8'h08, ROW_DATA,     1'b0, '0},
      '{8'hC3, ROW_DATA,     1'b0, '0},
      '{8'h3C, ROW_DATA,     1'b0, '0},
      '{8'h02, ROW_DATA,     1'b0, '0},
      '{8'hFD, ROW_DATA,     1'b0, '0},
      '{8'h00, ROW_CHECK_LO, 1'b0, '0},
      '{8'h00, ROW_CHECK_HI, 1'b0, '0},
      '{8'h44, ROW_DATA,     1'b0, '0},
      '{8'h47, ROW_DATA,     1'b0, '0},
      '{8'h00, ROW_DATA,     1'b0, '0}
   };

   // bitwise reflected X.25 update
   function automatic logic [15:0] crc16_x25_update(input logic [15:0] crc,
                                                    input logic [7:0] data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = acc >> 1;
         if (fb) begin
            acc = acc ^ CrcPoly;
         end
      end
      return acc;
   endfunction

   function automatic logic deframe_byte(input logic [7:0] b, output frame_word_type w);
      w = '0;
      if (!framing) begin
         if (saw_sync_first && b == SyncSecond) begin
            framing        = 1'b1;
            saw_sync_first = 1'b0;
            frame_offset   = 6'd2;
            crc_acc        = crc16_x25_update(crc16_x25_update(CrcInit, SyncFirst),
                                              SyncSecond);
         end else begin
            saw_sync_first = (b == SyncFirst);
         end
         return 1'b0;
      end
      w.frame_byte    = b;
      w.byte_position = frame_offset;
      if (frame_offset < FRAME_BYTES - 2) begin
         crc_acc      = crc16_x25_update(crc_acc, b);
         frame_offset = frame_offset + 6'd1;
      end else if (frame_offset == FRAME_BYTES - 2) begin
         check_low_byte = b;
         frame_offset   = frame_offset + 6'd1;
      end else begin
         w.frame_end    = 1'b1;
         w.check_passed = ({b, check_low_byte} == (crc_acc ^ CrcXorOut));
         framing        = 1'b0;
         saw_sync_first = 1'b0;
         frame_offset   = '0;
         crc_acc        = CrcInit;
         check_low_byte = '0;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_word_type typed_word);
      int unsigned    gap;
      frame_word_type w;
      logic           has_word;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'($urandom_range(255));
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      has_word = deframe_byte(b, w);
      if (typed) begin
         expected_words.push_back(typed_word);
         words_predicted++;
      end else if (has_word) begin
         expected_words.push_back(w);
         words_predicted++;
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic send_random_frame();
      int unsigned kind;
      int unsigned noise;
      logic [7:0]  b;
      logic [15:0] mask;
      kind  = $urandom_range(99);
      noise = $urandom_range(2);
      repeat (noise) send_byte(8'($urandom_range(255)), 1'b0, '0);
      if (kind < 10) begin
         // broken header
         b = 8'($urandom_range(255));
         if (b == SyncSecond) b = ~b;
         send_byte(SyncFirst, 1'b0, '0);
         send_byte(b, 1'b0, '0);
      end else begin
         if (kind < 25) send_byte(SyncFirst, 1'b0, '0);
         send_byte(SyncFirst, 1'b0, '0);
         send_byte(SyncSecond, 1'b0, '0);
         repeat (FRAME_BYTES - 4) begin
            if ($urandom_range(7) == 0) begin
               b = $urandom_range(1) ? SyncFirst : SyncSecond;
            end else begin
               b = 8'($urandom_range(255));
            end
            send_byte(b, 1'b0, '0);
         end
         mask = (kind >= 85) ? 16'($urandom_range(65535, 1)) : 16'h0000;
         planned_check = (crc_acc ^ CrcXorOut) ^ mask;
         send_byte(planned_check[7:0], 1'b0, '0);
         send_byte(planned_check[15:8], 1'b0, '0);
      end
   endtask

   // result side: random ready, long hold-offs, in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               $error("unexpected frame word 0x%0h at position %0d",
                      rsp_bus.frame_byte, rsp_bus.byte_position);
               mismatch_count++;
            end else begin
               frame_word_type want;
               want = expected_words.pop_front();
               check_field("frame_byte", want.frame_byte, rsp_bus.frame_byte);
               check_field("byte_position", 8'(want.byte_position), 8'(rsp_bus.byte_position));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_bus.frame_end));
               check_field("check_passed", 8'(want.check_passed), 8'(rsp_bus.check_passed));
               if (want.frame_end) begin
                  if (want.check_passed) frames_good++;
                  else frames_bad++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_words.size());
         $display("tb_sync_crc16_frame_receiver_core: FAIL");
         $finish;
      end
   end

   initial begin
      logic [7:0]  b;
      int unsigned frame_idx;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CHECK_LO: begin
               planned_check = crc_acc ^ CrcXorOut;
               b = planned_check[7:0];
            end
            ROW_CHECK_HI: b = planned_check[15:8];
            default:      b = directed_rows[i].rx_byte;
         endcase
         send_byte(b, directed_rows[i].typed, directed_rows[i].word);
      end
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 19; recv_idle_pct = 68; end
            1: begin send_idle_pct = 68; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         frame_idx = 0;
         while (bytes_sent < WORD_TARGET * (phase + 1) / 3) begin
            if (frame_idx == 4) stall_left = 150;
            if (frame_idx == 9) wait_drained();
            send_random_frame();
            frame_idx++;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("sent %0d bytes, checked %0d of %0d predicted frame words over %0d cycles",
               bytes_sent, words_checked, words_predicted, cycle_count);
      $display("frames ending with good check: %0d, with bad check: %0d",
               frames_good, frames_bad);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("tb_sync_crc16_frame_receiver_core: PASS");
      end else begin
         $display("tb_sync_crc16_frame_receiver_core: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/scfr_pkg.sv
rtl/scfr_req_if.sv
rtl/scfr_rsp_if.sv
rtl/scfr_crc16_unit.sv
rtl/sync_crc16_frame_receiver_core.sv
verif/tb_sync_crc16_frame_receiver_core.sv
